// ===== rtl/terminal_line_editor_defines.svh =====
// Assertion macros shared by the terminal line editor RTL.
`ifndef TERMINAL_LINE_EDITOR_DEFINES_SVH
`define TERMINAL_LINE_EDITOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge of clk outside reset.
`define TLE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge of clk outside reset.
`define TLE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tle_pkg.sv =====
// Package with the types, codes and constants of the terminal line editor.
`timescale 1ns / 1ps

package tle_pkg;

  // Default line store depth.
  localparam int LINE_SIZE_DEF = 16;

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam logic CFG_REG_MAX_LENGTH = 1'b0;
  localparam logic CFG_REG_SYNC_CODE  = 1'b1;
  localparam logic [4:0] MAX_LENGTH_RESET = 5'd16;
  localparam logic [7:0] SYNC_CODE_RESET  = 8'd174;

  // Character codes.
  localparam logic [7:0] CH_ETX   = 8'd3;
  localparam logic [7:0] CH_ACK   = 8'd6;
  localparam logic [7:0] CH_BEL   = 8'd7;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_CAN   = 8'd24;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TILDE = 8'd126;
  localparam logic [7:0] CH_DEL   = 8'd127;

  typedef enum logic [1:0] {
    DEST_ECHO = 2'd0,
    DEST_HOST = 2'd1,
    DEST_END  = 2'd2
  } dest_t;

  typedef enum logic [2:0] {
    CLS_SYNC,
    CLS_CR,
    CLS_ERASE1,
    CLS_ERASEALL,
    CLS_ACK,
    CLS_STORE,
    CLS_BELL
  } cls_t;

  typedef enum logic [2:0] {
    SEL_BEL,
    SEL_BS,
    SEL_SP,
    SEL_CR,
    SEL_LF,
    SEL_CHAR,
    SEL_RAM,
    SEL_END
  } sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_ER_SP,
    S_ER_BS2,
    S_ER_BS1,
    S_CR_LF,
    S_CR_RD,
    S_CR_BYTE,
    S_CR_END
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic  load_char;
    logic  out_load;
    dest_t out_dest;
    sel_t  out_sel;
    logic  out_len_en;
    logic  out_sync;
    logic  out_last;
    logic  fill_inc;
    logic  fill_dec;
    logic  fill_clr;
    logic  idx_clr;
    logic  idx_inc;
    logic  rd_en;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    cls_t cls;
    logic fill_zero;
    logic fill_gt1;
    logic idx_last;
    logic slot_free;
  } sts_t;

endpackage

// ===== rtl/tle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/tle_cfg.sv =====
// Configuration registers of the terminal line editor behind an APB-style port.
`timescale 1ns / 1ps

module tle_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tle_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  output logic [4:0]                  max_length,
  output logic [7:0]                  sync_code
);

  logic [4:0] max_length_r;
  logic [7:0] sync_code_r;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= tle_pkg::MAX_LENGTH_RESET;
      sync_code_r  <= tle_pkg::SYNC_CODE_RESET;
    end else if (wr_en) begin
      if (cfg_paddr[2] == tle_pkg::CFG_REG_MAX_LENGTH) begin
        max_length_r <= cfg_pwdata[4:0];
      end else begin
        sync_code_r <= cfg_pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == tle_pkg::CFG_REG_MAX_LENGTH) begin
      cfg_prdata = {27'd0, max_length_r};
    end else begin
      cfg_prdata = {24'd0, sync_code_r};
    end
  end

  assign max_length = max_length_r;
  assign sync_code  = sync_code_r;

endmodule

// ===== rtl/tle_ctrl.sv =====
// Controller state machine of the terminal line editor.
`timescale 1ns / 1ps
`include "terminal_line_editor_defines.svh"

module tle_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  tle_pkg::sts_t sts,
  output tle_pkg::cmd_t cmd
);

  tle_pkg::state_t state_r, state_nxt;
  logic            erase_all_r, erase_all_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tle_pkg::S_IDLE;
      erase_all_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      erase_all_r <= erase_all_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    erase_all_nxt  = erase_all_r;
    in_tready      = 1'b0;
    cmd.load_char  = 1'b0;
    cmd.out_load   = 1'b0;
    cmd.out_dest   = tle_pkg::DEST_ECHO;
    cmd.out_sel    = tle_pkg::SEL_BEL;
    cmd.out_len_en = 1'b0;
    cmd.out_sync   = 1'b0;
    cmd.out_last   = 1'b0;
    cmd.fill_inc   = 1'b0;
    cmd.fill_dec   = 1'b0;
    cmd.fill_clr   = 1'b0;
    cmd.idx_clr    = 1'b0;
    cmd.idx_inc    = 1'b0;
    cmd.rd_en      = 1'b0;

    case (state_r)
      tle_pkg::S_IDLE: begin
        in_tready     = 1'b1;
        cmd.load_char = in_tvalid;
        if (in_tvalid) begin
          state_nxt = tle_pkg::S_DECIDE;
        end
      end

      tle_pkg::S_DECIDE: begin
        if (sts.cls == tle_pkg::CLS_ACK) begin
          state_nxt = tle_pkg::S_IDLE;
        end else if ((sts.cls == tle_pkg::CLS_ERASE1 ||
                      sts.cls == tle_pkg::CLS_ERASEALL) && sts.fill_zero) begin
          state_nxt = tle_pkg::S_IDLE;
        end else if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          case (sts.cls)
            tle_pkg::CLS_SYNC: begin
              cmd.out_dest = tle_pkg::DEST_END;
              cmd.out_sel  = tle_pkg::SEL_END;
              cmd.out_sync = 1'b1;
              cmd.out_last = 1'b1;
              cmd.fill_clr = 1'b1;
              state_nxt    = tle_pkg::S_IDLE;
            end
            tle_pkg::CLS_CR: begin
              cmd.out_sel = tle_pkg::SEL_CR;
              state_nxt   = tle_pkg::S_CR_LF;
            end
            tle_pkg::CLS_ERASE1, tle_pkg::CLS_ERASEALL: begin
              cmd.out_sel   = tle_pkg::SEL_BS;
              erase_all_nxt = (sts.cls == tle_pkg::CLS_ERASEALL);
              state_nxt     = tle_pkg::S_ER_SP;
            end
            tle_pkg::CLS_STORE: begin
              cmd.out_sel  = tle_pkg::SEL_CHAR;
              cmd.out_last = 1'b1;
              cmd.fill_inc = 1'b1;
              state_nxt    = tle_pkg::S_IDLE;
            end
            default: begin
              cmd.out_sel  = tle_pkg::SEL_BEL;
              cmd.out_last = 1'b1;
              state_nxt    = tle_pkg::S_IDLE;
            end
          endcase
        end
      end

      tle_pkg::S_ER_SP: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = tle_pkg::SEL_SP;
          state_nxt    = tle_pkg::S_ER_BS2;
        end
      end

      tle_pkg::S_ER_BS2: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = tle_pkg::SEL_BS;
          cmd.fill_dec = 1'b1;
          if (erase_all_r && sts.fill_gt1) begin
            state_nxt = tle_pkg::S_ER_BS1;
          end else begin
            cmd.out_last = 1'b1;
            state_nxt    = tle_pkg::S_IDLE;
          end
        end
      end

      tle_pkg::S_ER_BS1: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = tle_pkg::SEL_BS;
          state_nxt    = tle_pkg::S_ER_SP;
        end
      end

      tle_pkg::S_CR_LF: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = tle_pkg::SEL_LF;
          cmd.idx_clr  = 1'b1;
          state_nxt    = sts.fill_zero ? tle_pkg::S_CR_END : tle_pkg::S_CR_RD;
        end
      end

      tle_pkg::S_CR_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = tle_pkg::S_CR_BYTE;
      end

      tle_pkg::S_CR_BYTE: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_dest = tle_pkg::DEST_HOST;
          cmd.out_sel  = tle_pkg::SEL_RAM;
          cmd.idx_inc  = 1'b1;
          state_nxt    = sts.idx_last ? tle_pkg::S_CR_END : tle_pkg::S_CR_RD;
        end
      end

      tle_pkg::S_CR_END: begin
        if (sts.slot_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_dest   = tle_pkg::DEST_END;
          cmd.out_sel    = tle_pkg::SEL_END;
          cmd.out_len_en = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.fill_clr   = 1'b1;
          state_nxt      = tle_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = tle_pkg::S_IDLE;
      end
    endcase
  end

  `TLE_ASSERT_IMP(a_load_into_free_slot, cmd.out_load, sts.slot_free,
                  "beat loaded over a pending beat")
  `TLE_ASSERT_NXT(a_last_returns_idle, cmd.out_load && cmd.out_last,
                  state_r == tle_pkg::S_IDLE, "no return to idle after the final beat")

endmodule

// ===== rtl/tle_dp.sv =====
// Datapath of the terminal line editor: character register, line store, counters, output stage.
`timescale 1ns / 1ps
`include "terminal_line_editor_defines.svh"

module tle_dp #(
  parameter int LINE_SIZE = tle_pkg::LINE_SIZE_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    in_tdata,
  input  logic [4:0]    max_length,
  input  logic [7:0]    sync_code,
  input  tle_pkg::cmd_t cmd,
  output tle_pkg::sts_t sts,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [15:0]   out_tdata,
  output logic [2:0]    out_tuser,
  output logic          out_tlast
);

  localparam int AW = $clog2(LINE_SIZE);
  localparam int FW = $clog2(LINE_SIZE + 1);

  logic [7:0]      char_r;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic [FW-1:0]   idx_r, idx_nxt;
  logic [4:0]      size_w, room_w;
  logic            has_room;
  logic [7:0]      ram_rdata;
  tle_pkg::cls_t   cls_w;

  logic            out_valid_r, out_valid_nxt;
  tle_pkg::dest_t  out_dest_r;
  logic [7:0]      out_data_r, out_data_nxt;
  logic [3:0]      out_len_r;
  logic            out_sync_r;
  logic            out_last_r;

  // Usable room: buffer size clamped to the store, one slot kept back.
  assign size_w   = (max_length > 5'(LINE_SIZE)) ? 5'(LINE_SIZE) : max_length;
  assign room_w   = (size_w != 5'd0) ? size_w - 5'd1 : 5'd0;
  assign has_room = 5'(fill_r) < room_w;

  always_comb begin
    if (char_r == sync_code) begin
      cls_w = tle_pkg::CLS_SYNC;
    end else if (char_r == tle_pkg::CH_CR) begin
      cls_w = tle_pkg::CLS_CR;
    end else if (char_r == tle_pkg::CH_BS || char_r == tle_pkg::CH_DEL) begin
      cls_w = tle_pkg::CLS_ERASE1;
    end else if (char_r == tle_pkg::CH_CAN || char_r == tle_pkg::CH_ETX ||
                 char_r == tle_pkg::CH_VT) begin
      cls_w = tle_pkg::CLS_ERASEALL;
    end else if (char_r == tle_pkg::CH_ACK) begin
      cls_w = tle_pkg::CLS_ACK;
    end else if (char_r >= tle_pkg::CH_SPACE && char_r <= tle_pkg::CH_TILDE && has_room) begin
      cls_w = tle_pkg::CLS_STORE;
    end else begin
      cls_w = tle_pkg::CLS_BELL;
    end
  end

  assign sts.cls       = cls_w;
  assign sts.fill_zero = (fill_r == '0);
  assign sts.fill_gt1  = (fill_r > FW'(1));
  assign sts.idx_last  = (FW'(idx_r + FW'(1)) == fill_r);
  assign sts.slot_free = !out_valid_r || out_tready;

  tle_ram #(
    .WIDTH(8),
    .DEPTH(LINE_SIZE)
  ) u_line_store (
    .clk   (clk),
    .we    (cmd.fill_inc),
    .waddr (fill_r[AW-1:0]),
    .wdata (char_r),
    .re    (cmd.rd_en),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.fill_clr) begin
      fill_nxt = '0;
    end else if (cmd.fill_inc) begin
      fill_nxt = fill_r + FW'(1);
    end else if (cmd.fill_dec) begin
      fill_nxt = fill_r - FW'(1);
    end
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + FW'(1);
    end
  end

  always_comb begin
    case (cmd.out_sel)
      tle_pkg::SEL_BEL:  out_data_nxt = tle_pkg::CH_BEL;
      tle_pkg::SEL_BS:   out_data_nxt = tle_pkg::CH_BS;
      tle_pkg::SEL_SP:   out_data_nxt = tle_pkg::CH_SPACE;
      tle_pkg::SEL_CR:   out_data_nxt = tle_pkg::CH_CR;
      tle_pkg::SEL_LF:   out_data_nxt = tle_pkg::CH_LF;
      tle_pkg::SEL_CHAR: out_data_nxt = char_r;
      tle_pkg::SEL_RAM:  out_data_nxt = ram_rdata;
      default:           out_data_nxt = 8'd0;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      char_r <= in_tdata;
    end
    if (cmd.out_load) begin
      out_dest_r <= cmd.out_dest;
      out_data_r <= out_data_nxt;
      out_len_r  <= cmd.out_len_en ? 4'(fill_r) : 4'd0;
      out_sync_r <= cmd.out_sync;
      out_last_r <= cmd.out_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_len_r, out_data_r};
  assign out_tuser  = {out_sync_r, out_dest_r};
  assign out_tlast  = out_last_r;

  `TLE_ASSERT_IMP(a_fill_within_store, 1'b1, fill_r <= FW'(LINE_SIZE - 1),
                  "fill count beyond the line store")
  `TLE_ASSERT_IMP(a_read_written_only, cmd.rd_en, idx_r < fill_r,
                  "line store read above the fill count")

endmodule

// ===== rtl/terminal_line_editor.sv =====
// Top level of the terminal line editor with echo.
`timescale 1ns / 1ps

// Terminal line editor: takes one received character per input beat and
// answers with a run of result beats, the final one marked by out_tlast.
// Printable characters are stored and echoed while there is room (up to
// max_length minus one, clamped to LINE_SIZE minus one), otherwise a bell is
// echoed; backspace and delete erase one character, cancel, ETX and VT the
// whole line, each erased character echoing backspace, space, backspace.
// Carriage return echoes CR and LF, sends the stored line to the host and
// closes with a line end beat carrying the length; the sync code clears the
// line and gives a line end beat flagged as sync. ACK, and an erase on an
// empty line, produce no beats. One character is handled at a time: the
// controller accepts a character in S_IDLE and decodes it in S_DECIDE,
// which already loads the first result beat once the output register is
// free; each further beat is loaded in a later state. A carriage return
// reads each line byte in S_CR_RD, as the line store read is registered,
// and loads it into the output register in S_CR_BYTE. The output register
// holds a finished beat while the next character is accepted, and stalls
// on out_tready only delay the run. The line store has no reset; the fill
// count alone says which entries are valid. Configuration registers
// (max_length at byte address 0, sync_code at address 4) are to be written
// by the user only while the block is idle; the block does not enforce it.
module terminal_line_editor #(
  parameter int LINE_SIZE = tle_pkg::LINE_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input channel.
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] rx_char
  // Result channel.
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,  // [7:0] data_byte, [11:8] line_length
  output logic [2:0]                  out_tuser,  // [1:0] dest, [2] sync_seen
  output logic                        out_tlast,
  // Configuration port.
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tle_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  logic [4:0]    max_length;
  logic [7:0]    sync_code;
  tle_pkg::cmd_t cmd;
  tle_pkg::sts_t sts;

  // Register block: buffer size and sync character.
  tle_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .max_length  (max_length),
    .sync_code   (sync_code)
  );

  // Controller: sequences the beats of each character.
  tle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: classifies the character, keeps the line and drives the result beats.
  tle_dp #(
    .LINE_SIZE(LINE_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .max_length (max_length),
    .sync_code  (sync_code),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== tb/tb_terminal_line_editor.sv =====
// Self-checking testbench for the terminal line editor with echo and its line store.
`timescale 1ns / 1ps

// Drives received characters into the editor over the input stream, predicts
// every echo, host and line end beat from a private copy of the line store,
// the fill count and both configuration registers, and compares each result
// beat field by field with the oldest prediction. Both sides of the stream
// idle at random, and once the result side holds off for a long stretch so
// that the editor fills up and stalls its input.
module tb_terminal_line_editor;
  import tle_pkg::*;

  localparam int LINE_DEPTH      = LINE_SIZE_DEF;
  localparam int CLK_HALF        = 6;
  // The longest single character is a full-line cancel.
  localparam int SETTLE_CYCLES   = 64;
  localparam int HOLD_OFF_CYCLES = 400;
  // Longest quiet spell in a correct run: the hold-off plus a long gap on
  // each side plus a register pause, comfortably below this.
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int PHASE_CHARS     = 50;
  localparam int NUM_PHASES      = 10;

  // One result beat as the editor presents it.
  typedef struct {
    dest_t      dest;
    logic [7:0] data_byte;
    logic [3:0] line_length;
    logic       sync_seen;
    logic       last;
  } beat_t;

  // Tracks the edited line and holds the beats that are still owed.
  class echo_line_tracker;
    logic [7:0]  line_chars [LINE_DEPTH];
    int unsigned chars_held;
    logic [4:0]  size_reg;
    logic [7:0]  sync_char;
    beat_t       pending_beats [$];
    beat_t       run [$];
    int unsigned mismatches;
    int unsigned chars_taken;
    int unsigned beats_checked;
    int unsigned lines_sent;
    int unsigned syncs_seen;
    int unsigned bells;

    function new();
      chars_held    = 0;
      size_reg      = MAX_LENGTH_RESET;
      sync_char     = SYNC_CODE_RESET;
      mismatches    = 0;
      chars_taken   = 0;
      beats_checked = 0;
      lines_sent    = 0;
      syncs_seen    = 0;
      bells         = 0;
    endfunction

    function void add(dest_t d, logic [7:0] b, logic [3:0] len, logic s);
      beat_t x;
      x.dest        = d;
      x.data_byte   = b;
      x.line_length = len;
      x.sync_seen   = s;
      x.last        = 1'b0;
      run.push_back(x);
    endfunction

    // Each erased character is rubbed out on the terminal as BS, space, BS.
    function void erase(int unsigned n);
      while (n > 0 && chars_held > 0) begin
        add(DEST_ECHO, CH_BS, 4'd0, 1'b0);
        add(DEST_ECHO, CH_SPACE, 4'd0, 1'b0);
        add(DEST_ECHO, CH_BS, 4'd0, 1'b0);
        n--;
        chars_held--;
      end
    endfunction

    function void note_char(logic [7:0] c);
      int unsigned size;
      int unsigned room;
      int unsigned i;
      beat_t       tail;
      chars_taken++;
      run.delete();
      // Sizes above the store depth act as the depth; one slot is always kept spare.
      size = (size_reg > LINE_DEPTH) ? LINE_DEPTH : size_reg;
      room = (size > 0) ? size - 1 : 0;
      // The sync code is tested first, so it wins even when it equals another code.
      if (c == sync_char) begin
        chars_held = 0;
        add(DEST_END, 8'd0, 4'd0, 1'b1);
        syncs_seen++;
      end else if (c == CH_CR) begin
        add(DEST_ECHO, CH_CR, 4'd0, 1'b0);
        add(DEST_ECHO, CH_LF, 4'd0, 1'b0);
        for (i = 0; i < chars_held; i++) add(DEST_HOST, line_chars[i], 4'd0, 1'b0);
        add(DEST_END, 8'd0, 4'(chars_held), 1'b0);
        chars_held = 0;
        lines_sent++;
      end else if (c == CH_BS || c == CH_DEL) begin
        erase(1);
      end else if (c == CH_CAN || c == CH_ETX || c == CH_VT) begin
        erase(chars_held);
      end else if (c == CH_ACK) begin
        // Acknowledge is swallowed without any echo.
      end else if (c >= CH_SPACE && c <= CH_TILDE && chars_held < room) begin
        line_chars[chars_held] = c;
        chars_held++;
        add(DEST_ECHO, c, 4'd0, 1'b0);
      end else begin
        add(DEST_ECHO, CH_BEL, 4'd0, 1'b0);
        bells++;
      end
      if (run.size() > 0) begin
        tail = run[run.size() - 1];
        tail.last = 1'b1;
        run[run.size() - 1] = tail;
      end
      foreach (run[k]) pending_beats.push_back(run[k]);
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      beats_checked++;
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected: dest %0d, data_byte %0d",
               got.dest, got.data_byte);
        mismatches++;
        return;
      end
      want = pending_beats.pop_front();
      if (got.dest !== want.dest) begin
        $error("dest: expected %0d, got %0d", want.dest, got.dest);
        mismatches++;
      end
      if (got.data_byte !== want.data_byte) begin
        $error("data_byte: expected %0d, got %0d", want.data_byte, got.data_byte);
        mismatches++;
      end
      if (got.line_length !== want.line_length) begin
        $error("line_length: expected %0d, got %0d", want.line_length, got.line_length);
        mismatches++;
      end
      if (got.sync_seen !== want.sync_seen) begin
        $error("sync_seen: expected %0d, got %0d", want.sync_seen, got.sync_seen);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;     // [7:0] rx_char
  logic              out_tvalid;
  logic              out_tready;
  logic [15:0]       out_tdata;    // [7:0] data_byte, [11:8] line_length
  logic [2:0]        out_tuser;    // [1:0] dest, [2] sync_seen
  logic              out_tlast;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  echo_line_tracker sb;
  int unsigned      chars_sent;
  int unsigned      settings_used;
  int unsigned      quiet_cycles;
  // calm switches idling off on both sides; hold_req asks the sink for a long hold-off.
  bit               calm;
  bit               hold_req;

  terminal_line_editor dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls, plus one long hold-off on request. The hold-off
  // is counted here so that the sender keeps offering characters meanwhile.
  initial begin : result_sink
    int unsigned stall;
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = calm ? 0 : idle_length();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Both channels are sampled at the clock edge, before any of this edge's
  // updates land, so accepted beats are seen exactly as the editor saw them.
  always @(posedge clk) begin
    beat_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_char(in_tdata);
      if (out_tvalid && out_tready) begin
        got.dest        = dest_t'(out_tuser[1:0]);
        got.data_byte   = out_tdata[7:0];
        got.line_length = out_tdata[11:8];
        got.sync_seen   = out_tuser[2];
        got.last        = out_tlast;
        sb.check_beat(got);
      end
    end
  end

  // Ends the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $error("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("terminal_line_editor regression: fail");
        $finish;
      end
    end
  end

  // Offers one character and waits for the editor to take it. The valid is only
  // lowered when a gap follows, so back-to-back beats keep it high throughout.
  task automatic send_char(input logic [7:0] c);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chars_sent++;
    gap = calm ? 0 : idle_length();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering, waits for every owed beat, then lets the controller drain
  // any character that owes nothing (ACK, an erase on an empty line).
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_read(input logic idx, output logic [31:0] value);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b0;
    cfg_paddr  <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    value = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Reads a register back and compares it with the tracker's copy.
  task automatic cfg_check(input logic idx);
    logic [31:0] value;
    cfg_read(idx, value);
    if (idx == CFG_REG_MAX_LENGTH) begin
      if (value[4:0] !== sb.size_reg) begin
        $error("max_length: expected %0d, got %0d", sb.size_reg, value[4:0]);
        sb.mismatches++;
      end
    end else if (value[7:0] !== sb.sync_char) begin
      $error("sync_code: expected %0d, got %0d", sb.sync_char, value[7:0]);
      sb.mismatches++;
    end
  endtask

  task automatic cfg_write(input logic idx, input logic [7:0] value);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= {idx, 2'b00};
    cfg_pwdata <= {24'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == CFG_REG_MAX_LENGTH) sb.size_reg = value[4:0];
    else sb.sync_char = value;
    cfg_check(idx);
  endtask

  // New settings are only ever applied with the editor idle.
  task automatic configure(input logic [4:0] size, input logic [7:0] sync);
    wait_idle();
    cfg_write(CFG_REG_MAX_LENGTH, {3'd0, size});
    cfg_write(CFG_REG_SYNC_CODE, sync);
    settings_used++;
  endtask

  // Mostly printable text with the odd rub-out, swallowed ACK or stray byte.
  function automatic logic [7:0] body_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 78) return 8'($urandom_range(CH_SPACE, CH_TILDE));
    else if (r < 86) return ($urandom_range(0, 1) != 0) ? CH_BS : CH_DEL;
    else if (r < 89) return CH_ACK;
    else return 8'($urandom_range(0, 255));
  endfunction

  // One line as a user would type it: some text, then usually a carriage
  // return, sometimes a sync or a line kill, and now and then nothing at all,
  // which leaves the line open into the next character or setting.
  task automatic type_line();
    int unsigned len;
    int unsigned r;
    len = $urandom_range(0, 18);
    repeat (len) send_char(body_char());
    r = $urandom_range(0, 99);
    if (r < 65) send_char(CH_CR);
    else if (r < 77) send_char(sb.sync_char);
    else if (r < 81) send_char(CH_CAN);
    else if (r < 85) send_char(CH_ETX);
    else if (r < 89) send_char(CH_VT);
  endtask

  initial begin : stimulus
    logic [4:0]  phase_size [NUM_PHASES];
    logic [7:0]  phase_sync [NUM_PHASES];
    int          p;
    int unsigned start;
    // Sizes run from no room at all past the store depth; the sync code is
    // placed on top of CR, the erase codes, ACK and a printable letter in turn.
    // A large size followed by a small one lowers the size over an open line.
    phase_size = '{5'd31, 5'd2, 5'd16, 5'd5, 5'd0, 5'd1, 5'd9, 5'd17, 5'd12, 5'd16};
    phase_sync = '{8'd174, 8'd0, CH_CR, 8'd255, CH_BS, CH_ACK, 8'h41, CH_DEL, CH_CAN, 8'd174};
    sb            = new();
    chars_sent    = 0;
    settings_used = 0;
    quiet_cycles  = 0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= 8'd0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= 32'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_check(CFG_REG_MAX_LENGTH);
    cfg_check(CFG_REG_SYNC_CODE);

    // Directed opening with the reset settings: erase and ACK on an empty
    // line, printable extremes, control and high bytes that ring the bell,
    // a finished line, each kind of line kill, the sync code and an empty line.
    send_char(CH_BS);
    send_char(CH_ACK);
    send_char(8'h41);
    send_char(CH_SPACE);
    send_char(CH_TILDE);
    send_char(8'h1F);
    send_char(CH_DEL);
    send_char(8'h80);
    send_char(8'hFF);
    send_char(8'h00);
    send_char(CH_LF);
    send_char(CH_CR);
    send_char(CH_CAN);
    send_char(8'h78);
    send_char(8'h79);
    send_char(CH_ETX);
    send_char(8'h7A);
    send_char(CH_VT);
    send_char(8'h71);
    send_char(SYNC_CODE_RESET);
    send_char(CH_CR);
    // Sizes that leave no room, then the smallest useful one.
    configure(5'd0, SYNC_CODE_RESET);
    send_char(8'h63);
    configure(5'd1, SYNC_CODE_RESET);
    send_char(8'h64);
    configure(5'd2, SYNC_CODE_RESET);
    send_char(8'h61);
    send_char(8'h62);
    send_char(CH_CR);

    // Random lines under each setting. The third setting runs without idling
    // and with the long hold-off, so the editor backs up into its input.
    for (p = 0; p < NUM_PHASES; p++) begin
      configure(phase_size[p], phase_sync[p]);
      calm = (p == 2);
      if (p == 2) hold_req = 1'b1;
      start = chars_sent;
      while (chars_sent - start < PHASE_CHARS) type_line();
    end
    calm = 1'b0;

    wait_idle();
    $display("Sent %0d characters under %0d register settings; checked %0d result beats.",
             chars_sent, settings_used, sb.beats_checked);
    $display("Seen %0d host lines, %0d sync line ends and %0d bells; %0d mismatches.",
             sb.lines_sent, sb.syncs_seen, sb.bells, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("terminal_line_editor regression: pass");
    end else begin
      $display("terminal_line_editor regression: fail");
    end
    $finish;
  end

endmodule
